FILE: rtl/core/mme_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply engine package
// Shared widths, codes, controller/datapath structs and a helper function.
// ----------------------------------------------------------------------------
`default_nettype none

package mme_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned DIM_W   = 4;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned PROD_W  = 2 * DATA_W;
  localparam int unsigned TDATA_W = 40;  // row, col, value rounded up to bytes

  // Defaults for the top level parameters.
  localparam int unsigned MAX_DIM_DEF   = 8;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Configuration register map.
  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_ROWS  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INNER = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLS  = 2'd2;
  localparam logic [DIM_W-1:0] DIM_RESET = 4'd4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_A  = 2'd0,
    FUNC_LOAD_B  = 2'd1,
    FUNC_COMPUTE = 2'd2
  } func_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load_a;
    logic             load_b;
    logic             issue;
    logic             first;
    logic             last;
    logic             final_elem;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mme_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic busy;
    logic out_full;
    logic fin_pending;
  } mme_status_t;

  // A size of zero acts as one, a size above the maximum acts as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned max_dim);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (int'(v) > int'(max_dim)) begin
      res = DIM_W'(max_dim);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mme_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/mme_ctrl.sv
// ----------------------------------------------------------------------------
// Matrix multiply controller
// Accepts items, sequences the row, column and inner loops of a product.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_ctrl import mme_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire logic [FUNC_W-1:0]                   func_i,
  input  wire logic [DIM_W-1:0]                    rows_i,
  input  wire logic [DIM_W-1:0]                    inner_i,
  input  wire logic [DIM_W-1:0]                    cols_i,
  input  wire mme_status_t                         status_i,
  output      mme_cmd_t                            cmd_o,
  output      logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  rd_addr_a_o,
  output      logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  rd_addr_b_o
);

  localparam int unsigned CW = $clog2(MAX_DIM);
  localparam int unsigned DW = $clog2(MAX_DIM + 1);
  localparam int unsigned AW = $clog2(MAX_DIM * MAX_DIM);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_ISSUE
  } state_e;

  state_e         state_q;
  logic [CW-1:0]  i_q, j_q, k_q;
  logic [DW-1:0]  r_q, m_q, c_q;
  logic           accept;
  logic           i_last, j_last, k_last;
  func_e          func;

  assign func   = func_e'(func_i);
  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign i_last = (DW'(i_q) + DW'(1)) == r_q;
  assign j_last = (DW'(j_q) + DW'(1)) == c_q;
  assign k_last = (DW'(k_q) + DW'(1)) == m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      r_q     <= DW'(1);
      m_q     <= DW'(1);
      c_q     <= DW'(1);
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept && func == FUNC_COMPUTE) begin
            r_q     <= DW'(clamp_dim(rows_i, MAX_DIM));
            m_q     <= DW'(clamp_dim(inner_i, MAX_DIM));
            c_q     <= DW'(clamp_dim(cols_i, MAX_DIM));
            i_q     <= '0;
            j_q     <= '0;
            k_q     <= '0;
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          // One element in flight at a time; its result needs a free slot.
          if (!status_i.busy && !status_i.out_full) begin
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (k_last) begin
            k_q <= '0;
            if (i_last && j_last) begin
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_WAIT;
              if (j_last) begin
                j_q <= '0;
                i_q <= i_q + CW'(1);
              end else begin
                j_q <= j_q + CW'(1);
              end
            end
          end else begin
            k_q <= k_q + CW'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o            = '0;
    cmd_o.load_a     = accept && (func == FUNC_LOAD_A);
    cmd_o.load_b     = accept && (func == FUNC_LOAD_B);
    cmd_o.issue      = (state_q == ST_ISSUE);
    cmd_o.first      = (k_q == '0);
    cmd_o.last       = k_last;
    cmd_o.final_elem = i_last && j_last;
    cmd_o.row        = IDX_W'(i_q);
    cmd_o.col        = IDX_W'(j_q);
  end

  assign rd_addr_a_o = AW'(int'(i_q) * MAX_DIM + int'(k_q));
  assign rd_addr_b_o = AW'(int'(k_q) * MAX_DIM + int'(j_q));

endmodule

`default_nettype wire

FILE: rtl/core/mme_datapath.sv
// ----------------------------------------------------------------------------
// Matrix multiply datapath
// Element stores, multiply-accumulate pipeline, scaling and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_datapath import mme_pkg::*; #(
  parameter int unsigned MAX_DIM   = MAX_DIM_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire mme_cmd_t                           cmd_i,
  input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0] rd_addr_a_i,
  input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0] rd_addr_b_i,
  input  wire logic [IDX_W-1:0]                   ld_row_i,
  input  wire logic [IDX_W-1:0]                   ld_col_i,
  input  wire logic [DATA_W-1:0]                  ld_value_i,
  output      mme_status_t                        status_o,
  output      logic                               out_valid_o,
  input  wire logic                               out_ready_i,
  output      logic [IDX_W-1:0]                   out_row_o,
  output      logic [IDX_W-1:0]                   out_col_o,
  output      logic [DATA_W-1:0]                  out_value_o,
  output      logic                               out_sat_o,
  output      logic                               out_last_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned ACC_W = PROD_W + $clog2(MAX_DIM) + 1;
  localparam int unsigned HI_W  = ACC_W - DATA_W + 1;

  logic              ld_in_range;
  logic [AW-1:0]     ld_addr;
  logic [DATA_W-1:0] a_rdata, b_rdata;

  assign ld_in_range = (int'(ld_row_i) < MAX_DIM) && (int'(ld_col_i) < MAX_DIM);
  assign ld_addr     = AW'(int'(ld_row_i) * MAX_DIM + int'(ld_col_i));

  mme_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store_a (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load_a && ld_in_range),
    .waddr_i(ld_addr),
    .wdata_i(ld_value_i),
    .raddr_i(rd_addr_a_i),
    .rdata_o(a_rdata)
  );

  mme_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store_b (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load_b && ld_in_range),
    .waddr_i(ld_addr),
    .wdata_i(ld_value_i),
    .raddr_i(rd_addr_b_i),
    .rdata_o(b_rdata)
  );

  // Stage 1: read data arrives, stage 2: product, stage 3: accumulator.
  logic                     s1_valid_q, s2_valid_q, fin_q, out_valid_q;
  logic                     s1_first_q, s1_last_q, s1_final_q;
  logic                     s2_first_q, s2_last_q, s2_final_q, fin_final_q;
  logic [IDX_W-1:0]         s1_row_q, s1_col_q, s2_row_q, s2_col_q;
  logic [IDX_W-1:0]         fin_row_q, fin_col_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0]  acc_d, acc_q;
  logic signed [ACC_W-1:0]  scaled;
  logic [HI_W-1:0]          scaled_hi;
  logic                     fits;
  logic [DATA_W-1:0]        value_d, value_q;
  logic                     sat_q, last_q;
  logic [IDX_W-1:0]         row_q, col_q;

  assign prod_d = $signed(a_rdata) * $signed(b_rdata);
  assign acc_d  = (s2_first_q ? ACC_W'(0) : acc_q) + ACC_W'(prod_q);

  assign scaled    = acc_q >>> FRAC_BITS;
  assign scaled_hi = scaled[ACC_W-1:DATA_W-1];
  assign fits      = (&scaled_hi) || !(|scaled_hi);
  always_comb begin
    if (fits) begin
      value_d = scaled[DATA_W-1:0];
    end else if (scaled[ACC_W-1]) begin
      value_d = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      value_d = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.issue;
      s2_valid_q <= s1_valid_q;
      fin_q      <= s2_valid_q && s2_last_q;
      if (fin_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q <= cmd_i.first;
    s1_last_q  <= cmd_i.last;
    s1_final_q <= cmd_i.final_elem;
    s1_row_q   <= cmd_i.row;
    s1_col_q   <= cmd_i.col;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_final_q <= s1_final_q;
    s2_row_q   <= s1_row_q;
    s2_col_q   <= s1_col_q;
    prod_q     <= prod_d;
    if (s2_valid_q) begin
      acc_q       <= acc_d;
      fin_final_q <= s2_final_q;
      fin_row_q   <= s2_row_q;
      fin_col_q   <= s2_col_q;
    end
    if (fin_q) begin
      value_q <= value_d;
      sat_q   <= !fits;
      last_q  <= fin_final_q;
      row_q   <= fin_row_q;
      col_q   <= fin_col_q;
    end
  end

  assign status_o.busy        = s1_valid_q || s2_valid_q || fin_q;
  assign status_o.out_full    = out_valid_q && !out_ready_i;
  assign status_o.fin_pending = fin_q;

  assign out_valid_o = out_valid_q;
  assign out_row_o   = row_q;
  assign out_col_o   = col_q;
  assign out_value_o = value_q;
  assign out_sat_o   = sat_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

FILE: rtl/core/matrix_multiply_engine.sv
// ----------------------------------------------------------------------------
// Matrix multiply engine
// Fixed-point general matrix multiply over two loaded element stores.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Contents
// s_axis    in         tvalid/tready             load A, load B or compute
// m_axis    out        tvalid/tready             one product element per beat
// apb       in         psel/penable/pwrite       rows, inner and cols sizes
//
// A load beat is taken whenever the engine is idle. A compute beat produces
// rows*cols result beats; each element issues inner reads, then drains through
// the read, multiply and accumulate stages into the result stage before the
// next element is issued. Input is held off from a compute beat until all reads
// of the product are issued. A stalled result waits in the output register and
// holds up the next element only. Reset sets the sizes to 4 and leaves the
// element stores unwritten.
//
`default_nettype none

module matrix_multiply_engine import mme_pkg::*; #(
  parameter int unsigned MAX_DIM   = MAX_DIM_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Input stream.
  input  wire logic               s_axis_tvalid,
  output      logic               s_axis_tready,
  // row_index [2:0], col_index [5:3], element_value [37:6], zeros above.
  input  wire logic [TDATA_W-1:0] s_axis_tdata,
  // func [1:0].
  input  wire logic [FUNC_W-1:0]  s_axis_tuser,
  // Result stream.
  output      logic               m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // out_row [2:0], out_col [5:3], product_value [37:6], zeros above.
  output      logic [TDATA_W-1:0] m_axis_tdata,
  // saturated [0].
  output      logic               m_axis_tuser,
  output      logic               m_axis_tlast,
  // Configuration port.
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output      logic [DATA_W-1:0]  prdata,
  output      logic               pready
);

  localparam int unsigned AW = $clog2(MAX_DIM * MAX_DIM);

  // Size registers, written through the configuration port. Sizes are clamped
  // where a compute beat takes them, not here.
  logic [DIM_W-1:0]     rows_q, inner_q, cols_q;
  logic                 cfg_write;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DIM_RESET;
      inner_q <= DIM_RESET;
      cols_q  <= DIM_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_ROWS:  rows_q  <= pwdata[DIM_W-1:0];
        REG_INNER: inner_q <= pwdata[DIM_W-1:0];
        REG_COLS:  cols_q  <= pwdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROWS:  prdata = DATA_W'(rows_q);
      REG_INNER: prdata = DATA_W'(inner_q);
      REG_COLS:  prdata = DATA_W'(cols_q);
      default:   prdata = '0;
    endcase
  end

  // Controller and datapath.
  mme_cmd_t         dp_cmd;
  mme_status_t      dp_status;
  logic [AW-1:0]    rd_addr_a, rd_addr_b;
  logic [IDX_W-1:0] out_row, out_col;
  logic [DATA_W-1:0] out_value;

  mme_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .func_i     (s_axis_tuser),
    .rows_i     (rows_q),
    .inner_i    (inner_q),
    .cols_i     (cols_q),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd),
    .rd_addr_a_o(rd_addr_a),
    .rd_addr_b_o(rd_addr_b)
  );

  mme_datapath #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .rd_addr_a_i(rd_addr_a),
    .rd_addr_b_i(rd_addr_b),
    .ld_row_i   (s_axis_tdata[2:0]),
    .ld_col_i   (s_axis_tdata[5:3]),
    .ld_value_i (s_axis_tdata[37:6]),
    .status_o   (dp_status),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_row_o  (out_row),
    .out_col_o  (out_col),
    .out_value_o(out_value),
    .out_sat_o  (m_axis_tuser),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {{(TDATA_W - 2*IDX_W - DATA_W){1'b0}}, out_value, out_col, out_row};

`ifndef ASSERT_OFF
  // A finished element must never find the result register full and stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_status.fin_pending |-> !dp_status.out_full)
    else $error("finished element would overwrite a waiting result");

  // Store reads of a product never overlap with accepting input beats.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !dp_cmd.issue)
    else $error("read issued while input is accepted");

  // A new element starts only into an empty pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd.issue && dp_cmd.first) |-> !dp_status.busy)
    else $error("element started with the pipeline busy");
`endif

endmodule

`default_nettype wire
